>>> rtl/core/locked_fifo_frame_cache_directory_top_defines.svh
// Assertion macros for the frame cache directory.
`ifndef LOCKED_FIFO_FRAME_CACHE_DIRECTORY_TOP_DEFINES_SVH
`define LOCKED_FIFO_FRAME_CACHE_DIRECTORY_TOP_DEFINES_SVH

`ifndef SYNTH
`define LFCD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LFCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFCD_ASSERT(label, clk, rst, prop, msg)
`define LFCD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/core/lfcd_pkg.sv
package lfcd_pkg;

  localparam int MODE_W   = 2;
  localparam int FRAME_W  = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOCK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNLOCK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FAULT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOCK    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd5;

  typedef enum logic [2:0] {
    S_ACCEPT = 3'b001,
    S_SEARCH = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/lfcd_ctrl.sv
module lfcd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  lfcd_pkg::stat_t stat,
  output lfcd_pkg::cmd_t  cmd
);

  lfcd_pkg::state_t state;
  lfcd_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      lfcd_pkg::S_ACCEPT: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = lfcd_pkg::S_SEARCH;
        end
      end
      lfcd_pkg::S_SEARCH: begin
        cmd.search = 1'b1;
        state_next = lfcd_pkg::S_COMMIT;
      end
      lfcd_pkg::S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = lfcd_pkg::S_ACCEPT;
        end
      end
      default: begin
        state_next = lfcd_pkg::S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfcd_pkg::S_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/lfcd_datapath.sv
`include "locked_fifo_frame_cache_directory_top_defines.svh"

module lfcd_datapath #(
  parameter int SLOTS      = 16,
  parameter int FRAME_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lfcd_pkg::cmd_t                     cmd,
  output lfcd_pkg::stat_t                    stat,
  input  logic [lfcd_pkg::MODE_W-1:0]        mode,
  input  logic [lfcd_pkg::FRAME_W-1:0]       frame_number,
  input  logic                               cfg_wen,
  input  logic [lfcd_pkg::CAP_W-1:0]         cfg_wdata,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [lfcd_pkg::STATUS_W-1:0]      status,
  output logic [lfcd_pkg::SLOT_OUT_W-1:0]    slot,
  output logic                               evicted_valid,
  output logic [lfcd_pkg::FRAME_W-1:0]       evicted_frame
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > lfcd_pkg::CAP_W) ? CNT_W : lfcd_pkg::CAP_W;
  localparam int TAG_W  = (FRAME_BITS < lfcd_pkg::FRAME_W) ? FRAME_BITS : lfcd_pkg::FRAME_W;

  logic [lfcd_pkg::CAP_W-1:0]  cap;
  logic [lfcd_pkg::MODE_W-1:0] req_mode;
  logic [TAG_W-1:0]            req_tag;

  logic [TAG_W-1:0]  tag_mem [SLOTS];
  logic [SLOT_W-1:0] order   [SLOTS];
  logic [SLOT_W-1:0] order_up[SLOTS];
  logic [SLOTS-1:0]  slot_valid;
  logic [SLOTS-1:0]  slot_lock;
  logic [CNT_W-1:0]  order_count;

  logic              hit_found;
  logic [SLOT_W-1:0] hit_idx;
  logic              fill_go;
  logic [SLOT_W-1:0] free_idx;
  logic              vict_found;
  logic [SLOT_W-1:0] vict_pos;
  logic [SLOT_W-1:0] vict_slot;

  logic              hit_found_next;
  logic [SLOT_W-1:0] hit_idx_next;
  logic              free_found_next;
  logic [SLOT_W-1:0] free_idx_next;
  logic              vict_found_next;
  logic [SLOT_W-1:0] vict_pos_next;
  logic [SLOT_W-1:0] vict_slot_next;
  logic              fill_ok;

  logic                            is_access;
  logic                            do_lock;
  logic                            do_fill;
  logic                            do_repl;
  logic [lfcd_pkg::STATUS_W-1:0]   res_status;
  logic [lfcd_pkg::SLOT_OUT_W-1:0] res_slot;

  for (genvar g = 0; g < SLOTS; g++) begin : g_up
    if (g < SLOTS - 1) begin : g_mid
      assign order_up[g] = order[g + 1];
    end else begin : g_end
      assign order_up[g] = order[g];
    end
  end

  // lookup, free slot and oldest unlocked victim, all lowest-first
  always_comb begin
    hit_found_next  = 1'b0;
    hit_idx_next    = '0;
    free_found_next = 1'b0;
    free_idx_next   = '0;
    vict_found_next = 1'b0;
    vict_pos_next   = '0;
    vict_slot_next  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && (tag_mem[i] == req_tag)) begin
        hit_found_next = 1'b1;
        hit_idx_next   = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        free_found_next = 1'b1;
        free_idx_next   = SLOT_W'(i);
      end
      if ((CNT_W'(i) < order_count) && !slot_lock[order[i]]) begin
        vict_found_next = 1'b1;
        vict_pos_next   = SLOT_W'(i);
        vict_slot_next  = order[i];
      end
    end
    fill_ok = (CMP_W'(order_count) < CMP_W'(cap)) && (order_count < CNT_W'(SLOTS));
  end

  always_comb begin
    is_access = (req_mode == lfcd_pkg::MODE_ACCESS);
    do_lock   = ((req_mode == lfcd_pkg::MODE_LOCK) || (req_mode == lfcd_pkg::MODE_UNLOCK))
                && hit_found;
    do_fill   = is_access && !hit_found && fill_go;
    do_repl   = is_access && !hit_found && !fill_go && vict_found;
    res_status = lfcd_pkg::ST_MISSING;
    res_slot   = '0;
    case (req_mode)
      lfcd_pkg::MODE_ACCESS: begin
        if (hit_found) begin
          res_status = lfcd_pkg::ST_HIT;
          res_slot   = lfcd_pkg::SLOT_OUT_W'(hit_idx);
        end else if (fill_go) begin
          res_status = lfcd_pkg::ST_FILL;
          res_slot   = lfcd_pkg::SLOT_OUT_W'(free_idx);
        end else if (vict_found) begin
          res_status = lfcd_pkg::ST_REPLACE;
          res_slot   = lfcd_pkg::SLOT_OUT_W'(vict_slot);
        end else begin
          res_status = lfcd_pkg::ST_FAULT;
        end
      end
      lfcd_pkg::MODE_LOCK, lfcd_pkg::MODE_UNLOCK: begin
        if (hit_found) begin
          res_status = lfcd_pkg::ST_LOCK;
          res_slot   = lfcd_pkg::SLOT_OUT_W'(hit_idx);
        end
      end
      default: begin
        res_status = lfcd_pkg::ST_MISSING;
      end
    endcase
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_tag  <= frame_number[TAG_W-1:0];
    end
    if (cmd.search) begin
      hit_found  <= hit_found_next;
      hit_idx    <= hit_idx_next;
      fill_go    <= fill_ok && free_found_next;
      free_idx   <= free_idx_next;
      vict_found <= vict_found_next;
      vict_pos   <= vict_pos_next;
      vict_slot  <= vict_slot_next;
    end
    if (cmd.commit) begin
      status        <= res_status;
      slot          <= res_slot;
      evicted_valid <= do_repl;
      evicted_frame <= do_repl ? lfcd_pkg::FRAME_W'(tag_mem[vict_slot]) : '0;
      if (do_fill) begin
        tag_mem[free_idx] <= req_tag;
      end
      if (do_repl) begin
        tag_mem[vict_slot] <= req_tag;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (do_fill && (CNT_W'(i) == order_count)) begin
          order[i] <= free_idx;
        end
        if (do_repl) begin
          if ((SLOT_W'(i) >= vict_pos) && (CNT_W'(i + 1) < order_count)) begin
            order[i] <= order_up[i];
          end else if (CNT_W'(i + 1) == order_count) begin
            order[i] <= vict_slot;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap         <= lfcd_pkg::CAP_RESET;
      slot_valid  <= '0;
      slot_lock   <= '0;
      order_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cap <= cfg_wdata;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit && do_lock) begin
        slot_lock[hit_idx] <= (req_mode == lfcd_pkg::MODE_LOCK);
      end
      if (cmd.commit && do_fill) begin
        slot_valid[free_idx] <= 1'b1;
        slot_lock[free_idx]  <= 1'b0;
        order_count          <= order_count + 1'b1;
      end
      if (cmd.commit && do_repl) begin
        slot_lock[vict_slot] <= 1'b0;
      end
    end
  end

  `LFCD_ASSERT(a_count_matches_valid, clk, rst, $countones(slot_valid) == int'(order_count), "order count differs from valid slots")
  `LFCD_ASSERT(a_fill_advances, clk, rst, (cmd.commit && do_fill) |=> (order_count == $past(order_count) + 1'b1), "fill did not advance order count")
  `LFCD_ASSERT(a_evict_flag, clk, rst, out_valid |-> (evicted_valid == (status == lfcd_pkg::ST_REPLACE)), "evicted flag disagrees with status")
  `LFCD_ASSERT(a_commit_free, clk, rst, cmd.commit |-> (!out_valid || out_ready), "result written over a pending one")

endmodule

>>> rtl/core/locked_fifo_frame_cache_directory_top.sv
// An accepted request goes through search, then commit, where the result is registered;
// commit waits while an untaken result is pending. The directory handles one request at a time.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst, synchronous, active high): all slots free and unlocked, order empty,
// capacity 16, no result pending.
module locked_fifo_frame_cache_directory_top #(
  parameter int SLOTS      = 16,
  parameter int FRAME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // frame_number
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // slot[3:0], evicted_frame[19:4], zero[23:20]
  output logic [3:0]  m_tuser,   // status[2:0], evicted_valid[3]
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata  // cache_capacity
);

  lfcd_pkg::cmd_t  cmd;
  lfcd_pkg::stat_t stat;

  logic [lfcd_pkg::STATUS_W-1:0]   status;
  logic [lfcd_pkg::SLOT_OUT_W-1:0] slot;
  logic                            evicted_valid;
  logic [lfcd_pkg::FRAME_W-1:0]    evicted_frame;

  lfcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfcd_datapath #(
    .SLOTS      (SLOTS),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (s_tuser),
    .frame_number  (s_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .status        (status),
    .slot          (slot),
    .evicted_valid (evicted_valid),
    .evicted_frame (evicted_frame)
  );

  assign m_tdata = {4'd0, evicted_frame, slot};
  assign m_tuser = {evicted_valid, status};

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lfcd_pkg::MODE_W-1:0] MODE_NONE = 2'd3;  // reserved mode, no effect
  localparam int NUM_SLOTS   = 16;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 250000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [lfcd_pkg::STATUS_W-1:0]   status;
    logic [lfcd_pkg::SLOT_OUT_W-1:0] slot;
    logic                            evicted_valid;
    logic [lfcd_pkg::FRAME_W-1:0]    evicted_frame;
  } dir_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // frame_number
  logic [1:0]  s_tuser = '0;    // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // slot[3:0], evicted_frame[19:4], zero[23:20]
  logic [3:0]  m_tuser;         // status[2:0], evicted_valid[3]
  logic        cfg_wen = 1'b0;
  logic [4:0]  cfg_wdata = '0;  // cache_capacity

  locked_fifo_frame_cache_directory_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // directory model
  logic [lfcd_pkg::FRAME_W-1:0] dir_tag [NUM_SLOTS];
  bit                           dir_valid [NUM_SLOTS];
  bit                           dir_lock [NUM_SLOTS];
  logic [3:0]                   fifo_order [NUM_SLOTS];
  int                           slots_used;
  logic [lfcd_pkg::CAP_W-1:0]   capacity;
  dir_result_t                  expected_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  logic [15:0] frame_pool [POOL_SIZE];

  function automatic dir_result_t lookup_frame(input logic [1:0] mode,
                                               input logic [15:0] frame);
    dir_result_t r;
    int hit;
    int cap;
    int victim;
    r = '0;
    hit = -1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (hit < 0 && dir_valid[i] && dir_tag[i] == frame) hit = i;
    cap = (capacity > NUM_SLOTS) ? NUM_SLOTS : int'(capacity);

    if (mode == lfcd_pkg::MODE_LOCK || mode == lfcd_pkg::MODE_UNLOCK) begin
      if (hit < 0) begin
        r.status = lfcd_pkg::ST_MISSING;
      end else begin
        dir_lock[hit] = (mode == lfcd_pkg::MODE_LOCK);
        r.status = lfcd_pkg::ST_LOCK;
        r.slot = 4'(hit);
      end
      return r;
    end
    if (mode == MODE_NONE) begin
      r.status = lfcd_pkg::ST_MISSING;
      return r;
    end
    if (hit >= 0) begin
      r.status = lfcd_pkg::ST_HIT;
      r.slot = 4'(hit);
      return r;
    end
    if (slots_used < cap) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!dir_valid[i]) begin
          dir_valid[i] = 1'b1;
          dir_lock[i] = 1'b0;
          dir_tag[i] = frame;
          fifo_order[slots_used] = 4'(i);
          slots_used++;
          r.status = lfcd_pkg::ST_FILL;
          r.slot = 4'(i);
          return r;
        end
      end
    end
    // oldest unlocked slot is recycled to the back of the order
    for (int pos = 0; pos < slots_used; pos++) begin
      victim = fifo_order[pos];
      if (!dir_lock[victim]) begin
        for (int i = pos; i + 1 < slots_used; i++) fifo_order[i] = fifo_order[i + 1];
        fifo_order[slots_used - 1] = 4'(victim);
        r.status = lfcd_pkg::ST_REPLACE;
        r.slot = 4'(victim);
        r.evicted_valid = 1'b1;
        r.evicted_frame = dir_tag[victim];
        dir_tag[victim] = frame;
        dir_lock[victim] = 1'b0;
        return r;
      end
    end
    r.status = lfcd_pkg::ST_FAULT;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    dir_result_t want;
    if (rst) begin
      capacity = lfcd_pkg::CAP_RESET;
      slots_used = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        dir_valid[i] = 1'b0;
        dir_lock[i] = 1'b0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: tdata %0h tuser %0h", m_tdata, m_tuser);
          error_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("status", 16'(want.status), 16'(m_tuser[2:0]));
          check_field("slot", 16'(want.slot), 16'(m_tdata[3:0]));
          check_field("evicted_valid", 16'(want.evicted_valid), 16'(m_tuser[3]));
          check_field("evicted_frame", want.evicted_frame, m_tdata[19:4]);
        end
      end
      if (cfg_wen) capacity = cfg_wdata;
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(), lookup_frame(s_tuser, s_tdata));
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_idle_on || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic [15:0] frame);
    int gap;
    if (tx_idle_on && $urandom_range(99) < 16) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= frame;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic drain_directory();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    drain_directory();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [15:0] pick_cached_frame();
    int cached;
    int k;
    cached = 0;
    for (int i = 0; i < NUM_SLOTS; i++) if (dir_valid[i]) cached++;
    if (cached == 0 || $urandom_range(99) < 20)
      return frame_pool[$urandom_range(POOL_SIZE - 1)];
    k = $urandom_range(cached - 1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (dir_valid[i]) begin
        if (k == 0) return dir_tag[i];
        k--;
      end
    end
    return '0;
  endfunction

  task automatic send_random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 2)
      send_request(MODE_NONE, 16'($urandom));
    else if (pick < 12)
      send_request(lfcd_pkg::MODE_LOCK, pick_cached_frame());
    else if (pick < 24)
      send_request(lfcd_pkg::MODE_UNLOCK, pick_cached_frame());
    else if (pick < 31)
      send_request(lfcd_pkg::MODE_ACCESS, 16'($urandom));
    else
      send_request(lfcd_pkg::MODE_ACCESS, frame_pool[$urandom_range(POOL_SIZE - 1)]);
  endtask

  // nothing can be filled with capacity zero on an empty directory
  task automatic test_zero_capacity();
    write_capacity(5'd0);
    send_request(lfcd_pkg::MODE_ACCESS, 16'h0001);
    send_request(lfcd_pkg::MODE_LOCK, 16'h0001);
  endtask

  // capacity above slot count saturates
  task automatic test_fill_and_hit();
    write_capacity(5'd31);
    send_request(lfcd_pkg::MODE_ACCESS, 16'h0000);
    send_request(lfcd_pkg::MODE_ACCESS, 16'hFFFF);
    send_request(lfcd_pkg::MODE_ACCESS, 16'h0000);
    send_request(lfcd_pkg::MODE_ACCESS, 16'hAAAA);
    send_request(lfcd_pkg::MODE_ACCESS, 16'h5555);
    send_request(MODE_NONE, 16'hFFFF);
  endtask

  task automatic test_lock_rules();
    send_request(lfcd_pkg::MODE_LOCK, 16'h0000);
    send_request(lfcd_pkg::MODE_LOCK, 16'h1234);
    send_request(lfcd_pkg::MODE_UNLOCK, 16'h1234);
    // capacity below slots in use: misses replace, oldest unlocked first
    write_capacity(5'd2);
    send_request(lfcd_pkg::MODE_ACCESS, 16'h1111);
    send_request(lfcd_pkg::MODE_LOCK, 16'hAAAA);
    send_request(lfcd_pkg::MODE_LOCK, 16'h5555);
    send_request(lfcd_pkg::MODE_LOCK, 16'h1111);
    send_request(lfcd_pkg::MODE_ACCESS, 16'h2222);
    send_request(lfcd_pkg::MODE_UNLOCK, 16'hAAAA);
    send_request(lfcd_pkg::MODE_ACCESS, 16'h2222);
    send_request(lfcd_pkg::MODE_ACCESS, 16'h2222);
  endtask

  task automatic test_output_backpressure();
    write_capacity(5'd16);
    tx_idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_random_request();
    drain_directory();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [4:0] phase_cap [8] = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd12, 5'd2, 5'd16};
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_cap[p]);
      tx_idle_on = (p != 3);
      rx_idle_on = (p != 3);
      repeat (175) send_random_request();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    frame_pool[0] = 16'h0000;
    frame_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) frame_pool[i] = 16'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_zero_capacity();
    test_fill_and_hit();
    test_lock_rules();
    test_output_backpressure();
    test_random_traffic();

    drain_directory();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
